>>> rtl/core/aesp_pkg.sv
// Shared types and codes for the ANSI escape sequence parser.
// Used by aesp_front, aesp_queue, aesp_back and the top level.
`default_nettype none

package aesp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Byte classes, independent of parser state
    localparam logic [4:0] C_CANCEL   = 5'd0;   // anywhere to ground
    localparam logic [4:0] C_ANY_SOS  = 5'd1;   // C1 SOS/PM/APC
    localparam logic [4:0] C_ANY_ESC  = 5'd2;   // ESC
    localparam logic [4:0] C_ANY_DCS  = 5'd3;   // C1 DCS
    localparam logic [4:0] C_ANY_CSI  = 5'd4;   // C1 CSI
    localparam logic [4:0] C_ANY_OSC  = 5'd5;   // C1 OSC
    localparam logic [4:0] C_C0       = 5'd6;
    localparam logic [4:0] C_INTER    = 5'd7;   // 0x20-0x2f
    localparam logic [4:0] C_PARAM    = 5'd8;   // digits and ';'
    localparam logic [4:0] C_COLON    = 5'd9;
    localparam logic [4:0] C_PRIV     = 5'd10;  // 0x3c-0x3f
    localparam logic [4:0] C_FIN_P    = 5'd11;  // 'P'
    localparam logic [4:0] C_FIN_SOS  = 5'd12;  // 'X' '^' '_'
    localparam logic [4:0] C_FIN_CSI  = 5'd13;  // '['
    localparam logic [4:0] C_FIN_OSC  = 5'd14;  // ']'
    localparam logic [4:0] C_FINAL    = 5'd15;  // rest of 0x40-0x7e
    localparam logic [4:0] C_DEL      = 5'd16;
    localparam logic [4:0] C_HIGH     = 5'd17;  // 0xa0-0xff

    localparam logic [3:0] A_NONE     = 4'd0;
    localparam logic [3:0] A_EXEC     = 4'd1;
    localparam logic [3:0] A_PRINT    = 4'd2;
    localparam logic [3:0] A_CLEAR    = 4'd3;
    localparam logic [3:0] A_COLLECT  = 4'd4;
    localparam logic [3:0] A_PARAM    = 4'd5;
    localparam logic [3:0] A_ESCDISP  = 4'd6;
    localparam logic [3:0] A_CSIDISP  = 4'd7;
    localparam logic [3:0] A_HOOK     = 4'd8;
    localparam logic [3:0] A_PUT      = 4'd9;
    localparam logic [3:0] A_OSCSTART = 4'd10;
    localparam logic [3:0] A_OSCPUT   = 4'd11;

    localparam logic [3:0] S_GROUND    = 4'd0;
    localparam logic [3:0] S_ESC       = 4'd1;
    localparam logic [3:0] S_ESC_INT   = 4'd2;
    localparam logic [3:0] S_CSI_ENTRY = 4'd3;
    localparam logic [3:0] S_CSI_PARAM = 4'd4;
    localparam logic [3:0] S_CSI_INT   = 4'd5;
    localparam logic [3:0] S_CSI_IGN   = 4'd6;
    localparam logic [3:0] S_DCS_ENTRY = 4'd7;
    localparam logic [3:0] S_DCS_PARAM = 4'd8;
    localparam logic [3:0] S_DCS_INT   = 4'd9;
    localparam logic [3:0] S_DCS_PASS  = 4'd10;
    localparam logic [3:0] S_DCS_IGN   = 4'd11;
    localparam logic [3:0] S_OSC       = 4'd12;
    localparam logic [3:0] S_SOS       = 4'd13;

    typedef struct packed {
        logic [7:0] data;
        logic [4:0] cls;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/ansi_escape_sequence_parser.sv
// VT500-style escape sequence parser, top level.
// Depends on aesp_pkg, aesp_front, aesp_queue, aesp_back.
//
// Takes one terminal byte per transfer and returns one result per byte: the
// action it triggers, the byte itself and the parser state after it. The front
// end classifies each byte and writes it into a 4-entry queue; the back end
// runs the state machine and holds the result in an output register. The
// sustained rate is one byte per clock while the output side accepts; each
// byte passes through the queue and then the output register. Output
// stalls are absorbed by the queue and the output register, so input keeps
// flowing for up to five bytes while the output side is held.
`default_nettype none

module ansi_escape_sequence_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [3:0] action, [11:4] byte_out,
                                             // [15:12] next_state
);

    aesp_pkg::entry_t     wr_entry;
    aesp_pkg::entry_t     rd_entry;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;

    aesp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .full          (q_full),
        .s_axis_tready (s_axis_tready),
        .push          (q_push),
        .entry         (wr_entry)
    );

    aesp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .pop      (q_pop),
        .wr_entry (wr_entry),
        .rd_entry (rd_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    aesp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (q_empty),
        .rd_entry      (rd_entry),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/aesp_front.sv
// Front end: accepts input bytes and tags each with its byte class.
// Depends on aesp_pkg.
`default_nettype none

module aesp_front (
    input  wire logic            s_axis_tvalid,
    input  wire logic [7:0]      s_axis_tdata,
    input  wire logic            full,
    output logic                 s_axis_tready,
    output logic                 push,
    output aesp_pkg::entry_t     entry
);

    logic [7:0] b;
    logic [4:0] cls;

    assign b = s_axis_tdata;

    always_comb
    begin
        priority if (b == 8'h18 || b == 8'h1a || (b >= 8'h80 && b <= 8'h8f) ||
                     (b >= 8'h91 && b <= 8'h97) || b == 8'h99 || b == 8'h9a ||
                     b == 8'h9c)
            cls = aesp_pkg::C_CANCEL;
        else if (b == 8'h98 || b == 8'h9e || b == 8'h9f)
            cls = aesp_pkg::C_ANY_SOS;
        else if (b == 8'h1b)
            cls = aesp_pkg::C_ANY_ESC;
        else if (b == 8'h90)
            cls = aesp_pkg::C_ANY_DCS;
        else if (b == 8'h9b)
            cls = aesp_pkg::C_ANY_CSI;
        else if (b == 8'h9d)
            cls = aesp_pkg::C_ANY_OSC;
        else if (b < 8'h20)
            cls = aesp_pkg::C_C0;
        else if (b < 8'h30)
            cls = aesp_pkg::C_INTER;
        else if (b < 8'h3a || b == 8'h3b)
            cls = aesp_pkg::C_PARAM;
        else if (b == 8'h3a)
            cls = aesp_pkg::C_COLON;
        else if (b < 8'h40)
            cls = aesp_pkg::C_PRIV;
        else if (b == 8'h50)
            cls = aesp_pkg::C_FIN_P;
        else if (b == 8'h58 || b == 8'h5e || b == 8'h5f)
            cls = aesp_pkg::C_FIN_SOS;
        else if (b == 8'h5b)
            cls = aesp_pkg::C_FIN_CSI;
        else if (b == 8'h5d)
            cls = aesp_pkg::C_FIN_OSC;
        else if (b < 8'h7f)
            cls = aesp_pkg::C_FINAL;
        else if (b == 8'h7f)
            cls = aesp_pkg::C_DEL;
        else
            cls = aesp_pkg::C_HIGH;
    end

    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && !full;
    assign entry.data    = b;
    assign entry.cls     = cls;

endmodule

`default_nettype wire

>>> rtl/core/aesp_queue.sv
// Small FIFO of classified bytes between front and back.
// Depends on aesp_pkg.
`default_nettype none

module aesp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic                pop,
    input  wire aesp_pkg::entry_t    wr_entry,
    output aesp_pkg::entry_t         rd_entry,
    output logic                     full,
    output logic                     empty
);

    localparam int AW = aesp_pkg::QUEUE_AW;

    aesp_pkg::entry_t slot_reg [aesp_pkg::QUEUE_DEPTH];
    logic [AW:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW:0]      rd_ptr_reg, rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                   (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);

    assign rd_entry    = slot_reg[rd_ptr_reg[AW-1:0]];
    assign wr_ptr_next = wr_ptr_reg + (AW+1)'(push);
    assign rd_ptr_next = rd_ptr_reg + (AW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg[AW-1:0]] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/aesp_back.sv
// Back end: parser state machine and registered result output.
// Depends on aesp_pkg.
`default_nettype none

module aesp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                empty,
    input  wire aesp_pkg::entry_t    rd_entry,
    output logic                     pop,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [15:0]              m_axis_tdata
);

    logic [3:0]  state_reg, state_next;
    logic        valid_reg, valid_next;
    logic [15:0] data_reg;
    logic [3:0]  act;
    logic [3:0]  st;
    logic [4:0]  c;
    logic        fin;
    logic        prn;

    assign c   = rd_entry.cls;
    assign fin = (c == aesp_pkg::C_FIN_P) || (c == aesp_pkg::C_FIN_SOS) ||
                 (c == aesp_pkg::C_FIN_CSI) || (c == aesp_pkg::C_FIN_OSC) ||
                 (c == aesp_pkg::C_FINAL);
    // 0x20-0x7f
    assign prn = fin || (c == aesp_pkg::C_INTER) || (c == aesp_pkg::C_PARAM) ||
                 (c == aesp_pkg::C_COLON) || (c == aesp_pkg::C_PRIV) ||
                 (c == aesp_pkg::C_DEL);

    always_comb
    begin
        act = aesp_pkg::A_NONE;
        st  = state_reg;
        priority if (c == aesp_pkg::C_CANCEL)
            st = aesp_pkg::S_GROUND;
        else if (c == aesp_pkg::C_ANY_SOS)
            st = aesp_pkg::S_SOS;
        else if (c == aesp_pkg::C_ANY_ESC)
        begin
            st = aesp_pkg::S_ESC; act = aesp_pkg::A_CLEAR;
        end
        else if (c == aesp_pkg::C_ANY_DCS)
        begin
            st = aesp_pkg::S_DCS_ENTRY; act = aesp_pkg::A_CLEAR;
        end
        else if (c == aesp_pkg::C_ANY_CSI)
        begin
            st = aesp_pkg::S_CSI_ENTRY; act = aesp_pkg::A_CLEAR;
        end
        else if (c == aesp_pkg::C_ANY_OSC)
        begin
            st = aesp_pkg::S_OSC; act = aesp_pkg::A_OSCSTART;
        end
        else
        begin
            unique case (state_reg)
                aesp_pkg::S_GROUND:
                begin
                    if (c == aesp_pkg::C_C0) act = aesp_pkg::A_EXEC;
                    else if (prn)            act = aesp_pkg::A_PRINT;
                end
                aesp_pkg::S_OSC:
                begin
                    if (prn) act = aesp_pkg::A_OSCPUT;
                end
                aesp_pkg::S_ESC:
                begin
                    if (c == aesp_pkg::C_C0) act = aesp_pkg::A_EXEC;
                    else if (c == aesp_pkg::C_FIN_SOS) st = aesp_pkg::S_SOS;
                    else if (c == aesp_pkg::C_FIN_P)
                    begin
                        act = aesp_pkg::A_CLEAR; st = aesp_pkg::S_DCS_ENTRY;
                    end
                    else if (c == aesp_pkg::C_FIN_CSI)
                    begin
                        act = aesp_pkg::A_CLEAR; st = aesp_pkg::S_CSI_ENTRY;
                    end
                    else if (c == aesp_pkg::C_FIN_OSC)
                    begin
                        act = aesp_pkg::A_OSCSTART; st = aesp_pkg::S_OSC;
                    end
                    else if (c == aesp_pkg::C_INTER)
                    begin
                        act = aesp_pkg::A_COLLECT; st = aesp_pkg::S_ESC_INT;
                    end
                    else if (fin || c == aesp_pkg::C_PARAM || c == aesp_pkg::C_COLON ||
                             c == aesp_pkg::C_PRIV)
                    begin
                        act = aesp_pkg::A_ESCDISP; st = aesp_pkg::S_GROUND;
                    end
                end
                aesp_pkg::S_ESC_INT:
                begin
                    if (c == aesp_pkg::C_C0) act = aesp_pkg::A_EXEC;
                    else if (c == aesp_pkg::C_INTER)  act = aesp_pkg::A_COLLECT;
                    else if (fin || c == aesp_pkg::C_PARAM || c == aesp_pkg::C_COLON ||
                             c == aesp_pkg::C_PRIV)
                    begin
                        act = aesp_pkg::A_ESCDISP; st = aesp_pkg::S_GROUND;
                    end
                end
                aesp_pkg::S_CSI_ENTRY:
                begin
                    if (c == aesp_pkg::C_C0) act = aesp_pkg::A_EXEC;
                    else if (c == aesp_pkg::C_PARAM)
                    begin
                        act = aesp_pkg::A_PARAM; st = aesp_pkg::S_CSI_PARAM;
                    end
                    else if (c == aesp_pkg::C_PRIV)
                    begin
                        act = aesp_pkg::A_COLLECT; st = aesp_pkg::S_CSI_PARAM;
                    end
                    else if (c == aesp_pkg::C_COLON) st = aesp_pkg::S_CSI_IGN;
                    else if (c == aesp_pkg::C_INTER)
                    begin
                        act = aesp_pkg::A_COLLECT; st = aesp_pkg::S_CSI_INT;
                    end
                    else if (fin)
                    begin
                        act = aesp_pkg::A_CSIDISP; st = aesp_pkg::S_GROUND;
                    end
                end
                aesp_pkg::S_CSI_PARAM:
                begin
                    if (c == aesp_pkg::C_C0) act = aesp_pkg::A_EXEC;
                    else if (c == aesp_pkg::C_PARAM)  act = aesp_pkg::A_PARAM;
                    else if (c == aesp_pkg::C_COLON || c == aesp_pkg::C_PRIV)
                        st = aesp_pkg::S_CSI_IGN;
                    else if (c == aesp_pkg::C_INTER)
                    begin
                        act = aesp_pkg::A_COLLECT; st = aesp_pkg::S_CSI_INT;
                    end
                    else if (fin)
                    begin
                        act = aesp_pkg::A_CSIDISP; st = aesp_pkg::S_GROUND;
                    end
                end
                aesp_pkg::S_CSI_INT:
                begin
                    if (c == aesp_pkg::C_C0) act = aesp_pkg::A_EXEC;
                    else if (c == aesp_pkg::C_INTER)  act = aesp_pkg::A_COLLECT;
                    else if (c == aesp_pkg::C_PARAM || c == aesp_pkg::C_COLON ||
                             c == aesp_pkg::C_PRIV)
                        st = aesp_pkg::S_CSI_IGN;
                    else if (fin)
                    begin
                        act = aesp_pkg::A_CSIDISP; st = aesp_pkg::S_GROUND;
                    end
                end
                aesp_pkg::S_CSI_IGN:
                begin
                    if (c == aesp_pkg::C_C0) act = aesp_pkg::A_EXEC;
                    else if (fin)            st  = aesp_pkg::S_GROUND;
                end
                aesp_pkg::S_DCS_ENTRY:
                begin
                    if (c == aesp_pkg::C_INTER)
                    begin
                        act = aesp_pkg::A_COLLECT; st = aesp_pkg::S_DCS_INT;
                    end
                    else if (c == aesp_pkg::C_PARAM)
                    begin
                        act = aesp_pkg::A_PARAM; st = aesp_pkg::S_DCS_PARAM;
                    end
                    else if (c == aesp_pkg::C_PRIV)
                    begin
                        act = aesp_pkg::A_COLLECT; st = aesp_pkg::S_DCS_PARAM;
                    end
                    else if (c == aesp_pkg::C_COLON) st = aesp_pkg::S_DCS_IGN;
                    else if (fin)
                    begin
                        act = aesp_pkg::A_HOOK; st = aesp_pkg::S_DCS_PASS;
                    end
                end
                aesp_pkg::S_DCS_PARAM:
                begin
                    if (c == aesp_pkg::C_PARAM) act = aesp_pkg::A_PARAM;
                    else if (c == aesp_pkg::C_COLON || c == aesp_pkg::C_PRIV)
                        st = aesp_pkg::S_DCS_IGN;
                    else if (c == aesp_pkg::C_INTER)
                    begin
                        act = aesp_pkg::A_COLLECT; st = aesp_pkg::S_DCS_INT;
                    end
                    else if (fin)
                    begin
                        act = aesp_pkg::A_HOOK; st = aesp_pkg::S_DCS_PASS;
                    end
                end
                aesp_pkg::S_DCS_INT:
                begin
                    if (c == aesp_pkg::C_INTER) act = aesp_pkg::A_COLLECT;
                    else if (c == aesp_pkg::C_PARAM || c == aesp_pkg::C_COLON ||
                             c == aesp_pkg::C_PRIV)
                        st = aesp_pkg::S_DCS_IGN;
                    else if (fin)
                    begin
                        act = aesp_pkg::A_HOOK; st = aesp_pkg::S_DCS_PASS;
                    end
                end
                aesp_pkg::S_DCS_PASS:
                begin
                    // DEL is dropped in passthrough
                    if (c == aesp_pkg::C_C0 || (prn && c != aesp_pkg::C_DEL))
                        act = aesp_pkg::A_PUT;
                end
                default:
                begin
                    // dcs ignore, sos/pm/apc and unused codes hold
                end
            endcase
        end
    end

    // Output register drains or is empty: take the next queued byte
    assign pop        = !empty && (!valid_reg || m_axis_tready);
    assign valid_next = pop || (valid_reg && !m_axis_tready);
    assign state_next = pop ? st : state_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= {st, rd_entry.data, act};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aesp_pkg::S_GROUND;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the ANSI escape sequence parser.
// Depends on aesp_pkg and ansi_escape_sequence_parser; no files or arguments.
`timescale 1ns / 1ps

module tb_top;

    localparam int N_RANDOM   = 400;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_DIRECTED = 25;

    // Same bit layout as m_axis_tdata: [3:0] action, [11:4] byte, [15:12] state
    typedef struct packed {
        logic [3:0] state;
        logic [7:0] ch;
        logic [3:0] action;
    } term_result_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;   // expectation typed in below, else predicted
        logic [3:0] action;
        logic [3:0] state;
    } dir_row_t;

    localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
        '{8'h00, 1'b1, aesp_pkg::A_EXEC,     aesp_pkg::S_GROUND},
        '{8'h41, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h7f, 1'b1, aesp_pkg::A_PRINT,    aesp_pkg::S_GROUND},    // DEL prints in ground
        '{8'hff, 1'b1, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h1b, 1'b1, aesp_pkg::A_CLEAR,    aesp_pkg::S_ESC},
        '{8'h28, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h42, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h9b, 1'b1, aesp_pkg::A_CLEAR,    aesp_pkg::S_CSI_ENTRY},
        '{8'h3f, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h32, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h3a, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h68, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h90, 1'b1, aesp_pkg::A_CLEAR,    aesp_pkg::S_DCS_ENTRY},
        '{8'h07, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},    // C0 ignored in dcs entry
        '{8'h71, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h07, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},    // C0 put in passthrough
        '{8'h9c, 1'b1, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h9d, 1'b1, aesp_pkg::A_OSCSTART, aesp_pkg::S_OSC},
        '{8'h7f, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h18, 1'b1, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h98, 1'b1, aesp_pkg::A_NONE,     aesp_pkg::S_SOS},
        '{8'h80, 1'b1, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},
        '{8'h1b, 1'b1, aesp_pkg::A_CLEAR,    aesp_pkg::S_ESC},
        '{8'h58, 1'b0, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND},    // ESC X opens a string
        '{8'h1a, 1'b1, aesp_pkg::A_NONE,     aesp_pkg::S_GROUND}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] byte_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [3:0] action, [11:4] byte_out, [15:12] next_state

    term_result_t expected_results[$];
    logic [3:0]   parser_state_model;
    logic [7:0]   seq_bytes[$];
    int           mismatch_count = 0;
    int           bytes_sent = 0;
    int           gap_pending = 0;
    int           burst_left = 0;
    int           idle_cycles = 0;
    int           ready_cycle = 0;
    int           ready_mode = 0;
    bit [15:0]    actions_seen;
    bit [15:0]    states_seen;

    ansi_escape_sequence_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit is_plain_c0(input logic [7:0] b);
        return (b <= 8'h17) || (b == 8'h19) || (b inside {[8'h1c:8'h1f]});
    endfunction

    // Next action and state for one byte from the given parser state
    function automatic term_result_t predict_term_result(input logic [7:0] b,
                                                          input logic [3:0] cur);
        term_result_t r;
        r.ch     = b;
        r.action = aesp_pkg::A_NONE;
        r.state  = cur;
        if (b == 8'h18 || b == 8'h1a || b inside {[8'h80:8'h8f]} ||
            b inside {[8'h91:8'h97]} || b == 8'h99 || b == 8'h9a || b == 8'h9c)
            r.state = aesp_pkg::S_GROUND;
        else if (b == 8'h98 || b == 8'h9e || b == 8'h9f)
            r.state = aesp_pkg::S_SOS;
        else if (b == 8'h1b)
        begin
            r.state = aesp_pkg::S_ESC; r.action = aesp_pkg::A_CLEAR;
        end
        else if (b == 8'h90)
        begin
            r.state = aesp_pkg::S_DCS_ENTRY; r.action = aesp_pkg::A_CLEAR;
        end
        else if (b == 8'h9b)
        begin
            r.state = aesp_pkg::S_CSI_ENTRY; r.action = aesp_pkg::A_CLEAR;
        end
        else if (b == 8'h9d)
        begin
            r.state = aesp_pkg::S_OSC; r.action = aesp_pkg::A_OSCSTART;
        end
        else
        begin
            case (cur)
                aesp_pkg::S_GROUND:
                    if (is_plain_c0(b)) r.action = aesp_pkg::A_EXEC;
                    else if (b inside {[8'h20:8'h7f]}) r.action = aesp_pkg::A_PRINT;
                aesp_pkg::S_OSC:
                    if (b inside {[8'h20:8'h7f]}) r.action = aesp_pkg::A_OSCPUT;
                aesp_pkg::S_ESC:
                    if (is_plain_c0(b)) r.action = aesp_pkg::A_EXEC;
                    else if (b == 8'h58 || b == 8'h5e || b == 8'h5f)
                        r.state = aesp_pkg::S_SOS;
                    else if (b == 8'h50)
                    begin
                        r.action = aesp_pkg::A_CLEAR; r.state = aesp_pkg::S_DCS_ENTRY;
                    end
                    else if (b == 8'h5b)
                    begin
                        r.action = aesp_pkg::A_CLEAR; r.state = aesp_pkg::S_CSI_ENTRY;
                    end
                    else if (b == 8'h5d)
                    begin
                        r.action = aesp_pkg::A_OSCSTART; r.state = aesp_pkg::S_OSC;
                    end
                    else if (b inside {[8'h20:8'h2f]})
                    begin
                        r.action = aesp_pkg::A_COLLECT; r.state = aesp_pkg::S_ESC_INT;
                    end
                    else if (b inside {[8'h30:8'h7e]})
                    begin
                        r.action = aesp_pkg::A_ESCDISP; r.state = aesp_pkg::S_GROUND;
                    end
                aesp_pkg::S_ESC_INT:
                    if (is_plain_c0(b)) r.action = aesp_pkg::A_EXEC;
                    else if (b inside {[8'h20:8'h2f]}) r.action = aesp_pkg::A_COLLECT;
                    else if (b inside {[8'h30:8'h7e]})
                    begin
                        r.action = aesp_pkg::A_ESCDISP; r.state = aesp_pkg::S_GROUND;
                    end
                aesp_pkg::S_CSI_ENTRY:
                    if (is_plain_c0(b)) r.action = aesp_pkg::A_EXEC;
                    else if (b inside {[8'h30:8'h39]} || b == 8'h3b)
                    begin
                        r.action = aesp_pkg::A_PARAM; r.state = aesp_pkg::S_CSI_PARAM;
                    end
                    else if (b inside {[8'h3c:8'h3f]})
                    begin
                        r.action = aesp_pkg::A_COLLECT; r.state = aesp_pkg::S_CSI_PARAM;
                    end
                    else if (b == 8'h3a) r.state = aesp_pkg::S_CSI_IGN;
                    else if (b inside {[8'h20:8'h2f]})
                    begin
                        r.action = aesp_pkg::A_COLLECT; r.state = aesp_pkg::S_CSI_INT;
                    end
                    else if (b inside {[8'h40:8'h7e]})
                    begin
                        r.action = aesp_pkg::A_CSIDISP; r.state = aesp_pkg::S_GROUND;
                    end
                aesp_pkg::S_CSI_PARAM:
                    if (is_plain_c0(b)) r.action = aesp_pkg::A_EXEC;
                    else if (b inside {[8'h30:8'h39]} || b == 8'h3b)
                        r.action = aesp_pkg::A_PARAM;
                    else if (b == 8'h3a || b inside {[8'h3c:8'h3f]})
                        r.state = aesp_pkg::S_CSI_IGN;
                    else if (b inside {[8'h20:8'h2f]})
                    begin
                        r.action = aesp_pkg::A_COLLECT; r.state = aesp_pkg::S_CSI_INT;
                    end
                    else if (b inside {[8'h40:8'h7e]})
                    begin
                        r.action = aesp_pkg::A_CSIDISP; r.state = aesp_pkg::S_GROUND;
                    end
                aesp_pkg::S_CSI_INT:
                    if (is_plain_c0(b)) r.action = aesp_pkg::A_EXEC;
                    else if (b inside {[8'h20:8'h2f]}) r.action = aesp_pkg::A_COLLECT;
                    else if (b inside {[8'h30:8'h3f]}) r.state = aesp_pkg::S_CSI_IGN;
                    else if (b inside {[8'h40:8'h7e]})
                    begin
                        r.action = aesp_pkg::A_CSIDISP; r.state = aesp_pkg::S_GROUND;
                    end
                aesp_pkg::S_CSI_IGN:
                    if (is_plain_c0(b)) r.action = aesp_pkg::A_EXEC;
                    else if (b inside {[8'h40:8'h7e]}) r.state = aesp_pkg::S_GROUND;
                aesp_pkg::S_DCS_ENTRY:
                    if (b inside {[8'h20:8'h2f]})
                    begin
                        r.action = aesp_pkg::A_COLLECT; r.state = aesp_pkg::S_DCS_INT;
                    end
                    else if (b inside {[8'h30:8'h39]} || b == 8'h3b)
                    begin
                        r.action = aesp_pkg::A_PARAM; r.state = aesp_pkg::S_DCS_PARAM;
                    end
                    else if (b inside {[8'h3c:8'h3f]})
                    begin
                        r.action = aesp_pkg::A_COLLECT; r.state = aesp_pkg::S_DCS_PARAM;
                    end
                    else if (b == 8'h3a) r.state = aesp_pkg::S_DCS_IGN;
                    else if (b inside {[8'h40:8'h7e]})
                    begin
                        r.action = aesp_pkg::A_HOOK; r.state = aesp_pkg::S_DCS_PASS;
                    end
                aesp_pkg::S_DCS_PARAM:
                    if (b inside {[8'h30:8'h39]} || b == 8'h3b)
                        r.action = aesp_pkg::A_PARAM;
                    else if (b == 8'h3a || b inside {[8'h3c:8'h3f]})
                        r.state = aesp_pkg::S_DCS_IGN;
                    else if (b inside {[8'h20:8'h2f]})
                    begin
                        r.action = aesp_pkg::A_COLLECT; r.state = aesp_pkg::S_DCS_INT;
                    end
                    else if (b inside {[8'h40:8'h7e]})
                    begin
                        r.action = aesp_pkg::A_HOOK; r.state = aesp_pkg::S_DCS_PASS;
                    end
                aesp_pkg::S_DCS_INT:
                    if (b inside {[8'h20:8'h2f]}) r.action = aesp_pkg::A_COLLECT;
                    else if (b inside {[8'h30:8'h3f]}) r.state = aesp_pkg::S_DCS_IGN;
                    else if (b inside {[8'h40:8'h7e]})
                    begin
                        r.action = aesp_pkg::A_HOOK; r.state = aesp_pkg::S_DCS_PASS;
                    end
                aesp_pkg::S_DCS_PASS:
                    if (is_plain_c0(b) || b inside {[8'h20:8'h7e]})
                        r.action = aesp_pkg::A_PUT;
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] pick(input int lo, input int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] pick_c0();
        logic [7:0] b;
        do
            b = pick(8'h00, 8'h1f);
        while (b == 8'h18 || b == 8'h1a || b == 8'h1b);
        return b;
    endfunction

    // Drive one byte, hold it until accepted, then queue its expected result
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input logic [3:0] act, input logic [3:0] st);
        term_result_t r;
        if (gap_pending > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_pending) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        r = predict_term_result(b, parser_state_model);
        parser_state_model = r.state;
        if (typed)
        begin
            r.action = act;
            r.state  = st;
        end
        expected_results.push_back(r);
        actions_seen[r.action] = 1'b1;
        states_seen[r.state]   = 1'b1;
        bytes_sent++;
        gap_pending = 0;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            gap_pending = $urandom_range(1, 6);
        end
    endtask

    // Append one sequence to seq_bytes: mostly well-formed, some noise
    task automatic build_sequence();
        int kind;
        int n;
        kind = $urandom_range(0, 19);
        case (kind)
            0, 1, 2:
            begin
                n = $urandom_range(1, 6);
                repeat (n) seq_bytes.push_back(pick(8'h20, 8'h7f));
            end
            3: seq_bytes.push_back(pick_c0());
            4, 5:
            begin
                seq_bytes.push_back(8'h1b);
                n = $urandom_range(0, 2);
                repeat (n) seq_bytes.push_back(pick(8'h20, 8'h2f));
                if ($urandom_range(0, 5) == 0) seq_bytes.push_back(pick_c0());
                seq_bytes.push_back(pick(8'h30, 8'h7e));
            end
            6, 7, 8, 9:
            begin
                if ($urandom_range(0, 1)) seq_bytes.push_back(8'h9b);
                else
                begin
                    seq_bytes.push_back(8'h1b);
                    seq_bytes.push_back(8'h5b);
                end
                if ($urandom_range(0, 3) == 0) seq_bytes.push_back(pick(8'h3c, 8'h3f));
                n = $urandom_range(0, 5);
                repeat (n)
                    seq_bytes.push_back($urandom_range(0, 3) == 0 ? 8'h3b : pick(8'h30, 8'h39));
                if ($urandom_range(0, 7) == 0) seq_bytes.push_back(8'h3a);
                if ($urandom_range(0, 7) == 0) seq_bytes.push_back(pick(8'h3c, 8'h3f));
                if ($urandom_range(0, 5) == 0) seq_bytes.push_back(pick_c0());
                n = $urandom_range(0, 2);
                repeat (n) seq_bytes.push_back(pick(8'h20, 8'h2f));
                if ($urandom_range(0, 9) == 0) seq_bytes.push_back(pick(8'h30, 8'h3f));
                seq_bytes.push_back(pick(8'h40, 8'h7e));
            end
            10, 11, 12:
            begin
                if ($urandom_range(0, 1)) seq_bytes.push_back(8'h90);
                else
                begin
                    seq_bytes.push_back(8'h1b);
                    seq_bytes.push_back(8'h50);
                end
                if ($urandom_range(0, 3) == 0) seq_bytes.push_back(pick(8'h3c, 8'h3f));
                n = $urandom_range(0, 4);
                repeat (n) seq_bytes.push_back(pick(8'h30, 8'h3b));
                if ($urandom_range(0, 5) == 0) seq_bytes.push_back(pick_c0());
                n = $urandom_range(0, 2);
                repeat (n) seq_bytes.push_back(pick(8'h20, 8'h2f));
                if ($urandom_range(0, 9) == 0) seq_bytes.push_back(pick(8'h30, 8'h3f));
                seq_bytes.push_back(pick(8'h40, 8'h7e));
                n = $urandom_range(0, 6);
                repeat (n)
                    seq_bytes.push_back($urandom_range(0, 3) == 0 ? pick_c0() : pick(8'h20, 8'h7f));
                if ($urandom_range(0, 1)) seq_bytes.push_back(8'h9c);
                else
                begin
                    seq_bytes.push_back(8'h1b);
                    seq_bytes.push_back(8'h5c);
                end
            end
            13, 14:
            begin
                if ($urandom_range(0, 1)) seq_bytes.push_back(8'h9d);
                else
                begin
                    seq_bytes.push_back(8'h1b);
                    seq_bytes.push_back(8'h5d);
                end
                n = $urandom_range(0, 6);
                repeat (n) seq_bytes.push_back(pick(8'h20, 8'h7f));
                case ($urandom_range(0, 2))
                    0: seq_bytes.push_back(8'h07);   // BEL is ignored inside OSC
                    1: seq_bytes.push_back(8'h9c);
                    default:
                    begin
                        seq_bytes.push_back(8'h1b);
                        seq_bytes.push_back(8'h5c);
                    end
                endcase
            end
            15, 16:
            begin
                case ($urandom_range(0, 3))
                    0: seq_bytes.push_back(8'h98);
                    1: seq_bytes.push_back(8'h9e);
                    2: seq_bytes.push_back(8'h9f);
                    default:
                    begin
                        seq_bytes.push_back(8'h1b);
                        case ($urandom_range(0, 2))
                            0: seq_bytes.push_back(8'h58);
                            1: seq_bytes.push_back(8'h5e);
                            default: seq_bytes.push_back(8'h5f);
                        endcase
                    end
                endcase
                n = $urandom_range(0, 5);
                repeat (n) seq_bytes.push_back(pick(8'h00, 8'h7f));
                seq_bytes.push_back(8'h9c);
            end
            default:
            begin
                n = $urandom_range(1, 4);
                repeat (n) seq_bytes.push_back(pick(8'h00, 8'hff));
            end
        endcase
    endtask

    // Receiver: drives m_axis_tready in one of four randomly chosen patterns
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            ready_cycle <= ready_cycle + 1;
            if (ready_cycle % 48 == 0)
                ready_mode <= $urandom_range(0, 3);
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= (ready_cycle % 4) != 3;
                2: m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= (ready_cycle % 4) == 0;
            endcase
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        term_result_t got;
        term_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = term_result_t'(m_axis_tdata);
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer: tdata=%h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.action !== exp_r.action)
                begin
                    $error("action: expected %0d, got %0d", exp_r.action, got.action);
                    mismatch_count++;
                end
                if (got.ch !== exp_r.ch)
                begin
                    $error("byte_out: expected %h, got %h", exp_r.ch, got.ch);
                    mismatch_count++;
                end
                if (got.state !== exp_r.state)
                begin
                    $error("next_state: expected %0d, got %0d", exp_r.state, got.state);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        bit paused;
        int directed_count;
        paused = 1'b0;
        parser_state_model = aesp_pkg::S_GROUND;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED[i].ch, DIRECTED[i].typed, DIRECTED[i].action,
                      DIRECTED[i].state);
        directed_count = bytes_sent;

        while (bytes_sent < directed_count + N_RANDOM)
        begin
            seq_bytes.delete();
            build_sequence();
            foreach (seq_bytes[k])
                send_byte(seq_bytes[k], 1'b0, aesp_pkg::A_NONE, aesp_pkg::S_GROUND);
            // hold the input off once until the output side has drained
            if (!paused && bytes_sent >= directed_count + N_RANDOM / 2)
            begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                gap_pending = 0;
                while (expected_results.size() != 0) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes (%0d directed) in well-formed and broken sequences",
                 bytes_sent, directed_count);
        $display("Actions seen: %0d of 12, parser states reached: %0d of 14",
                 $countones(actions_seen), $countones(states_seen));
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> ansi_escape_sequence_parser.f
rtl/core/aesp_pkg.sv
rtl/core/aesp_front.sv
rtl/core/aesp_queue.sv
rtl/core/aesp_back.sv
rtl/core/ansi_escape_sequence_parser.sv
tb/tb_top.sv
